FILE: src/bobps_pkg.sv
package bobps_pkg;

	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned LIMIT_W = 15;
	localparam int unsigned GAIN_W = 20;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 20;

	localparam int unsigned QUARTER_TURN = 23040;
	localparam int unsigned HALF_TURN = 46080;
	localparam int unsigned HALF_QUARTER = 11520;

	// A quarter turn is 512 * 45, so the index division splits into a shift and a
	// reciprocal multiply by 1/45 that is exact over the whole index range.
	localparam int unsigned QT_POW2_SHIFT = 9;
	localparam int unsigned QT_ODD = 45;
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned RECIP_W = 19;
	localparam int unsigned RECIP = (2 ** RECIP_SHIFT + QT_ODD - 1) / QT_ODD;

	localparam int unsigned PROD_W = WORD_W + GAIN_W;
	localparam int unsigned SUM_W = PROD_W + 1;

	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	typedef enum logic [1:0] {
		KIND_TICK     = 2'd0,
		KIND_TARGET   = 2'd1,
		KIND_POSITION = 2'd2,
		KIND_SPEED    = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ANGLE_LIMIT  = 3'd0,
		REG_SLEW_LIMIT   = 3'd1,
		REG_GRAVITY_STEP = 3'd2,
		REG_STEP_CM      = 3'd3,
		REG_STEP_SECONDS = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] operand;
	} item_t;

	typedef struct packed {
		logic signed [15:0] beam_angle;
		logic signed [31:0] ball_position;
		logic signed [31:0] velocity;
		logic [31:0]        elapsed_time;
		logic               on_beam;
	} result_t;

	typedef enum logic [3:0] {
		OP_COMMAND     = 4'd0,
		OP_SLEW        = 4'd1,
		OP_INDEX_SCALE = 4'd2,
		OP_INDEX_DIV   = 4'd3,
		OP_SINE_WAIT   = 4'd4,
		OP_MUL_SINE    = 4'd5,
		OP_SPEED       = 4'd6,
		OP_MUL_SPEED   = 4'd7,
		OP_POSITION    = 4'd8,
		OP_FINISH      = 4'd9
	} op_t;

	typedef enum logic {
		COND_NONE    = 1'b0,
		COND_COMMAND = 1'b1
	} cond_t;

	localparam int unsigned UPC_W = 4;
	localparam int unsigned PROGRAM_LEN = 10;
	localparam logic [UPC_W-1:0] FINISH_ADDR = 4'd9;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
		logic             last;
	} ucode_t;

	localparam ucode_t PROGRAM [PROGRAM_LEN] = '{
		'{op: OP_COMMAND,     cond: COND_COMMAND, target: FINISH_ADDR, last: 1'b0},
		'{op: OP_SLEW,        cond: COND_NONE,    target: '0,          last: 1'b0},
		'{op: OP_INDEX_SCALE, cond: COND_NONE,    target: '0,          last: 1'b0},
		'{op: OP_INDEX_DIV,   cond: COND_NONE,    target: '0,          last: 1'b0},
		'{op: OP_SINE_WAIT,   cond: COND_NONE,    target: '0,          last: 1'b0},
		'{op: OP_MUL_SINE,    cond: COND_NONE,    target: '0,          last: 1'b0},
		'{op: OP_SPEED,       cond: COND_NONE,    target: '0,          last: 1'b0},
		'{op: OP_MUL_SPEED,   cond: COND_NONE,    target: '0,          last: 1'b0},
		'{op: OP_POSITION,    cond: COND_NONE,    target: '0,          last: 1'b0},
		'{op: OP_FINISH,      cond: COND_NONE,    target: '0,          last: 1'b1}
	};

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-WORD_W:0] upper;
		upper = v[SUM_W-1:WORD_W-1];
		if (upper == '0 || upper == '1) begin
			return v[WORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end
	endfunction

endpackage

FILE: src/ball_on_beam_plant_step.sv
// Ball on a tilting beam, stepped in fixed point by explicit Euler integration.
// Input beats arrive on item (kind and operand) under item_valid/item_ready; each
// input beat yields exactly one result beat on result under result_valid/result_ready,
// reporting the angle, position, speed, elapsed time and on-beam flag after the item.
// The cfg_we/cfg_index/cfg_data port writes the five setup registers; write it only
// while the block is idle.
// A small microcode program steps a shared 32 by 20 multiplier and adder datapath.
// A tick runs ten steps; a set-target, set-position or set-speed command runs two
// steps. item_ready stays low while a program runs, so a new item is taken only
// after the program of the last one has finished. The sine table lookup costs three
// of the tick steps, the two products share the multiplier over four more.
// A finished result waits in the output register. If the receiver stalls, the next
// item is still taken and runs up to its last step, then holds there until the
// output register frees up.
// Reset restores the default register values, puts the ball at 50 cm at rest with a
// level beam and zero elapsed time, and leaves the block ready at once.
module ball_on_beam_plant_step
	import bobps_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = 256,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned SW = FRACTION_BITS + 1;
	localparam int unsigned NW = $clog2(QUARTER_TURN * (SINE_TABLE_DEPTH - 1) + HALF_QUARTER + 1);
	localparam int unsigned MW = NW - QT_POW2_SHIFT;
	localparam int unsigned QPW = MW + RECIP_W;
	localparam int unsigned QW = QPW - RECIP_SHIFT;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);
	localparam logic signed [WORD_W-1:0] BEAM_END = WORD_W'(100) << FRACTION_BITS;
	localparam logic signed [WORD_W-1:0] POSITION_RESET = WORD_W'(50) << FRACTION_BITS;

	logic [LIMIT_W-1:0]        angle_limit_q;
	logic [LIMIT_W-1:0]        slew_limit_q;
	logic [GAIN_W-1:0]         gravity_step_q;
	logic [GAIN_W-1:0]         step_cm_q;
	logic [GAIN_W-1:0]         step_seconds_q;

	logic signed [ANGLE_W-1:0] angle_q;
	logic signed [ANGLE_W-1:0] target_q;
	logic signed [WORD_W-1:0]  speed_q;
	logic signed [WORD_W-1:0]  position_q;
	logic [WORD_W-1:0]         time_q;

	logic                      busy_q;
	logic [UPC_W-1:0]          upc_q;
	logic                      result_valid_q;
	result_t                   result_q;

	kind_t                     kind_q;
	logic signed [WORD_W-1:0]  operand_q;
	logic [NW-1:0]             scaled_q;
	logic [IW-1:0]             idx_q;
	logic                      neg_q;
	logic [PROD_W-1:0]         prod_q;

	ucode_t                    uw;
	logic                      take;
	logic                      go;
	logic                      jump;

	logic signed [ANGLE_W:0]   diff;
	logic signed [ANGLE_W:0]   slew_ext;
	logic signed [ANGLE_W-1:0] angle_slewed;
	logic [WORD_W:0]           time_sum;
	logic signed [WORD_W-1:0]  limit_ext;
	logic signed [ANGLE_W-1:0] target_clamped;

	logic [ANGLE_W-1:0]        angle_mag;
	logic [ANGLE_W-1:0]        angle_fold;
	logic [NW-1:0]             scaled_next;
	logic [QPW-1:0]            quot_prod;
	logic [QW-1:0]             quot;
	logic [IW-1:0]             idx_next;
	logic [SW-1:0]             sine_mag;

	logic [WORD_W-1:0]         speed_abs;
	logic [WORD_W-1:0]         mul_a;
	logic [GAIN_W-1:0]         mul_b;
	logic [PROD_W-1:0]         prod_next;
	logic [PROD_W-1:0]         rounded;
	logic signed [SUM_W-1:0]   rounded_ext;
	logic signed [SUM_W-1:0]   speed_sum;
	logic signed [SUM_W-1:0]   position_sum;
	logic                      on_beam;

	assign uw = PROGRAM[upc_q];
	assign item_ready = !busy_q;
	assign take = item_valid && !busy_q;
	assign go = busy_q && (!uw.last || !result_valid_q || result_ready);
	assign jump = (uw.cond == COND_COMMAND) && (kind_q != KIND_TICK);

	assign result_valid = result_valid_q;
	assign result = result_q;

	assign diff = {target_q[ANGLE_W-1], target_q} - {angle_q[ANGLE_W-1], angle_q};
	assign slew_ext = {2'b00, slew_limit_q};
	assign time_sum = {1'b0, time_q} + (WORD_W + 1)'(step_seconds_q);
	assign limit_ext = WORD_W'(angle_limit_q);

	always_comb begin
		if (diff > slew_ext) begin
			angle_slewed = angle_q + ANGLE_W'(slew_limit_q);
		end else if (diff < -slew_ext) begin
			angle_slewed = angle_q - ANGLE_W'(slew_limit_q);
		end else begin
			angle_slewed = target_q;
		end
	end

	always_comb begin
		if (operand_q > limit_ext) begin
			target_clamped = ANGLE_W'(limit_ext);
		end else if (operand_q < -limit_ext) begin
			target_clamped = ANGLE_W'(-limit_ext);
		end else begin
			target_clamped = operand_q[ANGLE_W-1:0];
		end
	end

	// The sine is read at the nearest table entry of the angle folded into one quadrant.
	assign angle_mag = angle_q[ANGLE_W-1] ? ANGLE_W'(-angle_q) : ANGLE_W'(angle_q);
	assign angle_fold = (angle_mag > ANGLE_W'(QUARTER_TURN)) ?
		ANGLE_W'(HALF_TURN - angle_mag) : angle_mag;
	assign scaled_next = NW'(angle_fold[LIMIT_W-1:0]) * NW'(SINE_TABLE_DEPTH - 1)
		+ NW'(HALF_QUARTER);
	assign quot_prod = QPW'(scaled_q[NW-1:QT_POW2_SHIFT]) * QPW'(RECIP);
	assign quot = quot_prod[QPW-1:RECIP_SHIFT];
	assign idx_next = (quot > QW'(SINE_TABLE_DEPTH - 1)) ?
		IW'(SINE_TABLE_DEPTH - 1) : quot[IW-1:0];

	bobps_sine_rom #(
		.DEPTH(SINE_TABLE_DEPTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_sine_rom (
		.clk(clk),
		.addr(idx_q),
		.data(sine_mag)
	);

	assign speed_abs = speed_q[WORD_W-1] ? WORD_W'(-speed_q) : WORD_W'(speed_q);

	always_comb begin
		case (uw.op)
			OP_MUL_SPEED: begin
				mul_a = speed_abs;
				mul_b = step_cm_q;
			end
			default: begin
				mul_a = WORD_W'(sine_mag);
				mul_b = gravity_step_q;
			end
		endcase
	end

	assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Products are rounded half away from zero on the magnitude, then signed.
	assign rounded = (prod_q + ROUND_HALF) >> FRACTION_BITS;
	assign rounded_ext = {1'b0, rounded};
	assign speed_sum = SUM_W'(speed_q) + (neg_q ? rounded_ext : -rounded_ext);
	assign position_sum = SUM_W'(position_q) + (neg_q ? -rounded_ext : rounded_ext);
	assign on_beam = (position_q >= -BEAM_END) && (position_q <= BEAM_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_limit_q <= LIMIT_W'(7680);
			slew_limit_q <= LIMIT_W'(256);
			gravity_step_q <= GAIN_W'(6429);
			step_cm_q <= GAIN_W'(65536);
			step_seconds_q <= GAIN_W'(655);
			angle_q <= '0;
			target_q <= '0;
			speed_q <= '0;
			position_q <= POSITION_RESET;
			time_q <= '0;
			busy_q <= 1'b0;
			upc_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_LIMIT:  angle_limit_q <= cfg_data[LIMIT_W-1:0];
					REG_SLEW_LIMIT:   slew_limit_q <= cfg_data[LIMIT_W-1:0];
					REG_GRAVITY_STEP: gravity_step_q <= cfg_data;
					REG_STEP_CM:      step_cm_q <= cfg_data;
					REG_STEP_SECONDS: step_seconds_q <= cfg_data;
					default: ;
				endcase
			end

			if (go && uw.last) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			if (take) begin
				busy_q <= 1'b1;
				upc_q <= '0;
			end else if (go) begin
				if (uw.last) begin
					busy_q <= 1'b0;
				end else if (jump) begin
					upc_q <= uw.target;
				end else begin
					upc_q <= upc_q + UPC_W'(1);
				end

				case (uw.op)
					OP_COMMAND: begin
						case (kind_q)
							KIND_TARGET:   target_q <= target_clamped;
							KIND_POSITION: position_q <= operand_q;
							KIND_SPEED:    speed_q <= operand_q;
							default: ;
						endcase
					end
					OP_SLEW: begin
						angle_q <= angle_slewed;
						time_q <= time_sum[WORD_W] ? '1 : time_sum[WORD_W-1:0];
					end
					OP_SPEED:    speed_q <= sat32(speed_sum);
					OP_POSITION: position_q <= sat32(position_sum);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= item.kind;
			operand_q <= item.operand;
		end
		if (go) begin
			case (uw.op)
				OP_INDEX_SCALE: begin
					scaled_q <= scaled_next;
					neg_q <= angle_q[ANGLE_W-1];
				end
				OP_INDEX_DIV: idx_q <= idx_next;
				OP_MUL_SINE:  prod_q <= prod_next;
				OP_MUL_SPEED: begin
					prod_q <= prod_next;
					neg_q <= speed_q[WORD_W-1];
				end
				OP_FINISH: begin
					result_q.beam_angle <= angle_q;
					result_q.ball_position <= position_q;
					result_q.velocity <= speed_q;
					result_q.elapsed_time <= time_q;
					result_q.on_beam <= on_beam;
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: src/bobps_sine_rom.sv
module bobps_sine_rom
	import bobps_pkg::*;
#(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic                       clk,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	output logic [FRACTION_BITS:0]     data
);

	localparam int unsigned SW = FRACTION_BITS + 1;

	// Quarter-wave sine, Taylor series to the x^13 term in Q30, rounded to the output format.
	function automatic logic [SW-1:0] sine_entry(input int unsigned i);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		x = Q30_HALF_PI * 64'(i) / 64'(DEPTH - 1);
		x2 = (x * x) >> 30;
		sum = $signed(x);
		term = ((x * x2) >> 30) / 64'd6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (64'sd1 <<< 30)) begin
			sum = 64'sd1 <<< 30;
		end
		sum = (sum + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
		if (sum > (64'sd1 <<< FRACTION_BITS)) begin
			sum = 64'sd1 <<< FRACTION_BITS;
		end
		return sum[SW-1:0];
	endfunction

	logic [SW-1:0] rom [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		assign rom[g] = sine_entry(g);
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule

FILE: tb/ball_on_beam_plant_step_tb.sv
module ball_on_beam_plant_step_tb;
	import bobps_pkg::*;

	localparam int LUT_DEPTH = 256;
	localparam int FRAC = 16;
	localparam longint QUARTER_DEG = 23040;
	localparam longint HALF_DEG = 46080;
	localparam longint TIME_CEIL = 64'h0000_0000_FFFF_FFFF;
	localparam longint WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint WORD_MIN = -64'sh0000_0000_8000_0000;
	localparam int BEAM_EDGE = 100 * (1 << FRAC);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	item_t pending_items[$];
	result_t expected_results[$];
	bit item_accepted;
	bit steady;
	int fault_count;
	int cycle_count;

	int unsigned sine_lut [LUT_DEPTH];
	int unsigned limit_cfg;
	int unsigned slew_cfg;
	int unsigned gravity_cfg;
	int unsigned step_cm_cfg;
	int unsigned step_s_cfg;
	int angle_cur;
	int angle_goal;
	int speed_cur;
	int position_cur;
	int unsigned elapsed_cur;

	ball_on_beam_plant_step #(
		.SINE_TABLE_DEPTH(LUT_DEPTH),
		.FRACTION_BITS(FRAC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned sine_entry(int unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint acc;
		x = Q30_HALF_PI * 64'(i) / 64'(LUT_DEPTH - 1);
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
			if (k % 2 == 1) begin
				acc -= longint'(term);
			end else begin
				acc += longint'(term);
			end
		end
		if (acc < 0) acc = 0;
		if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
		acc = (acc + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
		if (acc > (longint'(1) << FRAC)) acc = longint'(1) << FRAC;
		return acc[31:0];
	endfunction

	// Magnitude times a non-negative gain, scaled down with rounding half away from zero.
	function automatic longint scale_round(longint a, longint b);
		longint mag;
		longint prod;
		mag = (a < 0) ? -a : a;
		prod = (mag * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
		return (a < 0) ? -prod : prod;
	endfunction

	function automatic int clip_word(longint v);
		if (v > WORD_MAX) return int'(WORD_MAX);
		if (v < WORD_MIN) return int'(WORD_MIN);
		return int'(v);
	endfunction

	function automatic result_t plant_step_expect(item_t it);
		longint opnd;
		longint gap;
		longint mag;
		longint idx;
		longint sine_val;
		result_t r;
		opnd = longint'($signed(it.operand));
		case (it.kind)
			KIND_TICK: begin
				gap = longint'(angle_goal) - longint'(angle_cur);
				if (gap > longint'(slew_cfg)) begin
					angle_cur = angle_cur + int'(slew_cfg);
				end else if (gap < -longint'(slew_cfg)) begin
					angle_cur = angle_cur - int'(slew_cfg);
				end else begin
					angle_cur = angle_goal;
				end
				mag = (angle_cur < 0) ? -longint'(angle_cur) : longint'(angle_cur);
				if (mag > QUARTER_DEG) mag = HALF_DEG - mag;
				if (mag < 0) mag = 0;
				idx = (mag * (LUT_DEPTH - 1) + QUARTER_DEG / 2) / QUARTER_DEG;
				if (idx > LUT_DEPTH - 1) idx = LUT_DEPTH - 1;
				sine_val = longint'(sine_lut[idx]);
				if (angle_cur < 0) sine_val = -sine_val;
				speed_cur = clip_word(longint'(speed_cur)
					- scale_round(sine_val, longint'(gravity_cfg)));
				position_cur = clip_word(longint'(position_cur)
					+ scale_round(longint'(speed_cur), longint'(step_cm_cfg)));
				gap = longint'(elapsed_cur) + longint'(step_s_cfg);
				elapsed_cur = (gap > TIME_CEIL) ? 32'hFFFF_FFFF : gap[31:0];
			end
			KIND_TARGET: begin
				if (opnd > longint'(limit_cfg)) begin
					opnd = longint'(limit_cfg);
				end else if (opnd < -longint'(limit_cfg)) begin
					opnd = -longint'(limit_cfg);
				end
				angle_goal = int'(opnd);
			end
			KIND_POSITION: begin
				position_cur = int'(opnd);
			end
			KIND_SPEED: begin
				speed_cur = int'(opnd);
			end
		endcase
		r.beam_angle = angle_cur[15:0];
		r.ball_position = position_cur;
		r.velocity = speed_cur;
		r.elapsed_time = elapsed_cur;
		r.on_beam = (position_cur >= -BEAM_EDGE) && (position_cur <= BEAM_EDGE);
		return r;
	endfunction

	task automatic log_fault(string msg);
		fault_count++;
		if (fault_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_result(result_t want, result_t got);
		if (got.beam_angle !== want.beam_angle)
			log_fault($sformatf("beam_angle expected %0d got %0d",
				want.beam_angle, got.beam_angle));
		if (got.ball_position !== want.ball_position)
			log_fault($sformatf("ball_position expected %0d got %0d",
				want.ball_position, got.ball_position));
		if (got.velocity !== want.velocity)
			log_fault($sformatf("velocity expected %0d got %0d",
				want.velocity, got.velocity));
		if (got.elapsed_time !== want.elapsed_time)
			log_fault($sformatf("elapsed_time expected %0d got %0d",
				want.elapsed_time, got.elapsed_time));
		if (got.on_beam !== want.on_beam)
			log_fault($sformatf("on_beam expected %0d got %0d", want.on_beam, got.on_beam));
	endtask

	task automatic queue_item(kind_t k, int op);
		item_t it;
		it.kind = k;
		it.operand = op;
		pending_items.push_back(it);
	endtask

	function automatic item_t random_plant_item();
		item_t it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60) begin
			it.kind = KIND_TICK;
			it.operand = $urandom;
		end else if (pick < 75) begin
			it.kind = KIND_TARGET;
			if ($urandom_range(3) == 0) begin
				it.operand = $urandom;
			end else begin
				it.operand = int'($urandom_range(48000)) - 24000;
			end
		end else if (pick < 88) begin
			it.kind = KIND_POSITION;
			case ($urandom_range(5))
				0: it.operand = $urandom;
				1: it.operand = BEAM_EDGE + int'($urandom_range(1));
				2: it.operand = -BEAM_EDGE - int'($urandom_range(1));
				default: it.operand = int'($urandom_range(300 * 65536)) - 150 * 65536;
			endcase
		end else begin
			it.kind = KIND_SPEED;
			if ($urandom_range(3) == 0) begin
				it.operand = $urandom;
			end else begin
				it.operand = int'($urandom_range(10 * 65536)) - 5 * 65536;
			end
		end
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_setup(cfg_reg_t which, int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value[CFG_DATA_W-1:0];
		case (which)
			REG_ANGLE_LIMIT: limit_cfg = value & 32'h7FFF;
			REG_SLEW_LIMIT: slew_cfg = value & 32'h7FFF;
			REG_GRAVITY_STEP: gravity_cfg = value & 32'hF_FFFF;
			REG_STEP_CM: step_cm_cfg = value & 32'hF_FFFF;
			REG_STEP_SECONDS: step_s_cfg = value & 32'hF_FFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_setup(int unsigned lim, int unsigned slew, int unsigned grav,
			int unsigned cm, int unsigned secs);
		write_setup(REG_ANGLE_LIMIT, lim);
		write_setup(REG_SLEW_LIMIT, slew);
		write_setup(REG_GRAVITY_STEP, grav);
		write_setup(REG_STEP_CM, cm);
		write_setup(REG_STEP_SECONDS, secs);
	endtask

	task automatic run_random(int count);
		for (int n = 0; n < count; n++) pending_items.push_back(random_plant_item());
		wait_drained();
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				expected_results.push_back(plant_step_expect(item));
				item_accepted = 1'b1;
			end
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					log_fault("result beat arrived with nothing expected");
				end else begin
					check_result(expected_results.pop_front(), result);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			result_ready <= 1'b0;
		end else begin
			result_ready <= steady || ($urandom_range(99) >= 30);
			if (!item_valid || item_accepted) begin
				item_accepted = 1'b0;
				if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
					item_valid <= 1'b1;
					item <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int ticks;
		item_t it;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		item_accepted = 1'b0;
		fault_count = 0;
		cycle_count = 0;
		for (int i = 0; i < LUT_DEPTH; i++) sine_lut[i] = sine_entry(i);
		limit_cfg = 7680;
		slew_cfg = 256;
		gravity_cfg = 6429;
		step_cm_cfg = 65536;
		step_s_cfg = 655;
		angle_cur = 0;
		angle_goal = 0;
		speed_cur = 0;
		position_cur = 50 * (1 << FRAC);
		elapsed_cur = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		queue_item(KIND_TICK, 0);
		queue_item(KIND_TARGET, 32'h7FFF_FFFF);
		queue_item(KIND_TICK, 0);
		queue_item(KIND_TICK, -1);
		queue_item(KIND_TARGET, 32'h8000_0000);
		queue_item(KIND_TICK, 0);
		queue_item(KIND_TARGET, 100);
		queue_item(KIND_TICK, 0);
		queue_item(KIND_POSITION, 32'h7FFF_FFFF);
		queue_item(KIND_SPEED, 32'h7FFF_FFFF);
		queue_item(KIND_TICK, 0);
		queue_item(KIND_POSITION, 32'h8000_0000);
		queue_item(KIND_SPEED, 32'h8000_0000);
		queue_item(KIND_TICK, 0);
		queue_item(KIND_POSITION, BEAM_EDGE);
		queue_item(KIND_POSITION, BEAM_EDGE + 1);
		queue_item(KIND_POSITION, -BEAM_EDGE);
		queue_item(KIND_POSITION, -BEAM_EDGE - 1);
		queue_item(KIND_SPEED, -65536);
		queue_item(KIND_TARGET, 7680);
		queue_item(KIND_TICK, 0);
		queue_item(KIND_SPEED, 0);
		queue_item(KIND_TARGET, -1);
		queue_item(KIND_TICK, 0);
		wait_drained();

		program_setup(23040, 23040, 20'hF_FFFF, 20'hF_FFFF, 0);
		queue_item(KIND_TARGET, 23040);
		queue_item(KIND_TICK, 0);
		queue_item(KIND_TARGET, -23040);
		queue_item(KIND_TICK, 0);
		run_random(150);

		program_setup(0, 0, 0, 0, 1);
		run_random(100);

		program_setup(16383, 16383, 20'h5_5555, 20'hA_AAAA, 20'h0_F0F0);
		run_random(100);

		for (int ph = 0; ph < 3; ph++) begin
			program_setup($urandom_range(23040), $urandom_range(1, 1024),
				$urandom_range(20000), $urandom_range(200000), $urandom_range(5000));
			steady = (ph == 1);
			run_random(150);
			steady = 1'b0;
		end

		// A short run of mostly ticks with the largest time step.
		program_setup(7680, 256, 6429, 65536, 20'hF_FFFF);
		ticks = 0;
		while (ticks < 30) begin
			if ($urandom_range(9) == 0) begin
				it = random_plant_item();
			end else begin
				it.kind = KIND_TICK;
				it.operand = $urandom;
			end
			if (it.kind == KIND_TICK) ticks++;
			pending_items.push_back(it);
		end
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
